// ===== design/jitp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package jitp_pkg;

    // Sizes and limits
    localparam int MAX_PAYLOAD = 8192;
    localparam int DIM_MAX     = 4096;
    localparam int KEY_LEN     = 11;
    localparam int CNT_W       = $clog2(MAX_PAYLOAD + 1);
    localparam int DIM_W       = 13;
    localparam int IDX_W       = 12;
    localparam int MAG_W       = 32;
    localparam int ACC_W       = MAG_W + 4;

    // Configuration register indexes
    localparam logic [1:0] CFG_NUM_PLANES = 2'd0;
    localparam logic [1:0] CFG_NUM_ROWS   = 2'd1;
    localparam logic [1:0] CFG_NUM_COLS   = 2'd2;

    // Status codes
    typedef logic [3:0] t_status;
    localparam t_status ST_OK       = 4'd0;
    localparam t_status ST_EMPTY    = 4'd1;
    localparam t_status ST_TOO_LONG = 4'd2;
    localparam t_status ST_NO_KEY   = 4'd3;
    localparam t_status ST_NO_COLON = 4'd4;
    localparam t_status ST_OPEN     = 4'd5;
    localparam t_status ST_NUMBER   = 4'd6;
    localparam t_status ST_COMMA    = 4'd7;
    localparam t_status ST_CLOSE    = 4'd8;

    // Result kinds
    localparam logic KIND_VALUE  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // Parser phases
    typedef enum logic [3:0] {
        PH_KEY,
        PH_COLON,
        PH_OPEN_TOP,
        PH_OPEN_PLANE,
        PH_OPEN_ROW,
        PH_NUM_START,
        PH_NUM_SIGN,
        PH_NUM_DIGITS,
        PH_AFTER_ROW,
        PH_AFTER_PLANE,
        PH_DONE,
        PH_ERR
    } t_phase;

    // Input beat
    typedef struct packed {
        logic [7:0] byte_req;
        logic       is_end;
    } t_in;

    // Result beat
    typedef struct packed {
        logic              kind;
        logic signed [7:0] value;
        logic [IDX_W-1:0]  plane_index;
        logic [IDX_W-1:0]  row_index;
        logic [IDX_W-1:0]  col_index;
        t_status           status;
    } t_out;

    // Clamp a size register to 1..DIM_MAX
    function automatic logic [DIM_W-1:0] dim_of(input logic [DIM_W-1:0] r);
        logic [DIM_W-1:0] d;
        begin
            if (r == '0) begin
                d = DIM_W'(1);
            end else if (r > DIM_W'(DIM_MAX)) begin
                d = DIM_W'(DIM_MAX);
            end else begin
                d = r;
            end
            return d;
        end
    endfunction

    function automatic logic is_ws(input logic [7:0] c);
        return (c == 8'h20) || (c == 8'h0A) || (c == 8'h0D) || (c == 8'h09) ||
               (c == 8'h0B) || (c == 8'h0C);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    // Characters of the quoted key, quotes included
    function automatic logic [7:0] key_char(input logic [3:0] pos);
        logic [7:0] k;
        begin
            unique case (pos)
                4'd0:    k = 8'h22;
                4'd1:    k = 8'h69;
                4'd2:    k = 8'h6E;
                4'd3:    k = 8'h74;
                4'd4:    k = 8'h5F;
                4'd5:    k = 8'h76;
                4'd6:    k = 8'h61;
                4'd7:    k = 8'h6C;
                4'd8:    k = 8'h75;
                4'd9:    k = 8'h65;
                4'd10:   k = 8'h22;
                default: k = 8'h00;
            endcase
            return k;
        end
    endfunction

endpackage

`default_nettype wire

// ===== design/json_int8_tensor_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel  Handshake                  Payload
// in       i_in_valid / o_in_ready    i_in  (byte_req, is_end)
// out      o_out_valid / i_out_ready  o_out (kind, value, indices, status)
// cfg      i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One byte beat per cycle while o_in_ready is high; each beat updates the
// parser; its result, if any, is registered into the output or skid buffer.
// The output register plus a one-entry skid buffer decouple the two sides;
// input stalls only while the skid buffer holds a result.
// Synchronous active-low reset clears parser state; sizes reset to 1.
// Configuration writes are always taken.
module json_int8_tensor_parser (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire jitp_pkg::t_in              i_in,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output jitp_pkg::t_out                  o_out,
    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic [1:0]                 i_cfg_index,
    input  wire logic [jitp_pkg::DIM_W-1:0] i_cfg_data
);
    import jitp_pkg::*;

    logic [DIM_W-1:0] r_num_planes;
    logic [DIM_W-1:0] r_num_rows;
    logic [DIM_W-1:0] r_num_cols;

    logic  in_accept;
    logic  res_valid;
    t_out  res;

    logic  r_out_valid;
    t_out  r_out;
    logic  r_skid_valid;
    t_out  r_skid;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_skid_valid;
    assign in_accept   = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Size registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_planes <= DIM_W'(1);
            r_num_rows   <= DIM_W'(1);
            r_num_cols   <= DIM_W'(1);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_NUM_PLANES: r_num_planes <= i_cfg_data;
                CFG_NUM_ROWS:   r_num_rows   <= i_cfg_data;
                CFG_NUM_COLS:   r_num_cols   <= i_cfg_data;
                default:        r_num_cols   <= r_num_cols;
            endcase
        end
    end

    jitp_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (in_accept),
        .i_beat       (i_in),
        .i_num_planes (r_num_planes),
        .i_num_rows   (r_num_rows),
        .i_num_cols   (r_num_cols),
        .o_res_valid  (res_valid),
        .o_res        (res)
    );

    // Output register with skid buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_out_valid && i_out_ready) begin
            if (r_skid_valid) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end else if (in_accept && res_valid) begin
                r_out <= res;
            end else begin
                r_out_valid <= 1'b0;
            end
        end else if (!r_out_valid) begin
            if (in_accept && res_valid) begin
                r_out       <= res;
                r_out_valid <= 1'b1;
            end
        end else if (in_accept && res_valid) begin
            // Hold the new result while the output stalls
            r_skid       <= res;
            r_skid_valid <= 1'b1;
        end
    end

endmodule

`default_nettype wire

// ===== design/jitp_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

module jitp_core (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_accept,
    input  wire jitp_pkg::t_in              i_beat,
    input  wire logic [jitp_pkg::DIM_W-1:0] i_num_planes,
    input  wire logic [jitp_pkg::DIM_W-1:0] i_num_rows,
    input  wire logic [jitp_pkg::DIM_W-1:0] i_num_cols,
    output logic                            o_res_valid,
    output jitp_pkg::t_out                  o_res
);
    import jitp_pkg::*;

    t_phase            r_phase,    n_phase;
    logic [3:0]        r_key_pos,  n_key_pos;
    logic [IDX_W-1:0]  r_plane,    n_plane;
    logic [IDX_W-1:0]  r_row,      n_row;
    logic [IDX_W-1:0]  r_col,      n_col;
    logic [MAG_W-1:0]  r_mag,      n_mag;
    logic              r_neg,      n_neg;
    logic [CNT_W-1:0]  r_bytes,    n_bytes;
    t_status           r_err,      n_err;

    logic [7:0]        c;
    logic [3:0]        digit;
    logic [ACC_W-1:0]  acc;
    logic [ACC_W-1:0]  limit;
    logic              col_last;
    logic              row_last;
    logic              plane_last;
    t_status           end_err;

    assign c     = i_beat.byte_req;
    assign digit = c[3:0];

    // Multiply-add by ten for the next digit
    assign acc   = {r_mag, 3'b000} + {2'b00, r_mag, 1'b0} + ACC_W'(digit);
    assign limit = r_neg ? ACC_W'(64'd2147483648) : ACC_W'(64'd2147483647);

    // Last element at each nesting level
    assign col_last   = ({1'b0, r_col} + DIM_W'(1))   >= dim_of(i_num_cols);
    assign row_last   = ({1'b0, r_row} + DIM_W'(1))   >= dim_of(i_num_rows);
    assign plane_last = ({1'b0, r_plane} + DIM_W'(1)) >= dim_of(i_num_planes);

    // Error of whatever is expected next
    always_comb begin
        unique case (r_phase)
            PH_KEY:                                 end_err = ST_NO_KEY;
            PH_COLON:                               end_err = ST_NO_COLON;
            PH_OPEN_TOP, PH_OPEN_PLANE, PH_OPEN_ROW: end_err = ST_OPEN;
            PH_NUM_START, PH_NUM_SIGN:              end_err = ST_NUMBER;
            PH_NUM_DIGITS:  end_err = col_last   ? ST_CLOSE : ST_COMMA;
            PH_AFTER_ROW:   end_err = row_last   ? ST_CLOSE : ST_COMMA;
            PH_AFTER_PLANE: end_err = plane_last ? ST_CLOSE : ST_COMMA;
            PH_ERR:                                 end_err = r_err;
            default:                                end_err = ST_OK;
        endcase
    end

    // Next state and result for one beat
    always_comb begin
        n_phase   = r_phase;
        n_key_pos = r_key_pos;
        n_plane   = r_plane;
        n_row     = r_row;
        n_col     = r_col;
        n_mag     = r_mag;
        n_neg     = r_neg;
        n_bytes   = r_bytes;
        n_err     = r_err;
        o_res_valid = 1'b0;
        o_res       = '0;

        if (i_beat.is_end) begin
            o_res_valid  = 1'b1;
            o_res.kind   = KIND_STATUS;
            if (r_bytes == '0) begin
                o_res.status = ST_EMPTY;
            end else if (r_bytes >= CNT_W'(MAX_PAYLOAD)) begin
                o_res.status = ST_TOO_LONG;
            end else begin
                o_res.status = end_err;
            end
            // Start the next file from scratch
            n_phase   = PH_KEY;
            n_key_pos = '0;
            n_plane   = '0;
            n_row     = '0;
            n_col     = '0;
            n_mag     = '0;
            n_neg     = 1'b0;
            n_bytes   = '0;
            n_err     = ST_OK;
        end else if (!is_ws(c) && (r_bytes < CNT_W'(MAX_PAYLOAD))) begin
            if (r_bytes >= CNT_W'(MAX_PAYLOAD - 1)) begin
                n_bytes = CNT_W'(MAX_PAYLOAD);
            end else begin
                n_bytes = r_bytes + CNT_W'(1);
                if ((r_phase != PH_DONE) && (r_phase != PH_ERR)) begin
                    if (c == 8'h00) begin
                        // Zero byte ends the text
                        n_err   = end_err;
                        n_phase = PH_ERR;
                    end else begin
                        unique case (r_phase)
                            PH_KEY: begin
                                if (c == key_char(r_key_pos)) begin
                                    n_key_pos = r_key_pos + 4'd1;
                                    if (r_key_pos == 4'(KEY_LEN - 1)) begin
                                        n_phase = PH_COLON;
                                    end
                                end else begin
                                    n_key_pos = (c == 8'h22) ? 4'd1 : 4'd0;
                                end
                            end
                            PH_COLON: begin
                                if (c == 8'h3A) begin
                                    n_phase = PH_OPEN_TOP;
                                end else begin
                                    n_err = ST_NO_COLON; n_phase = PH_ERR;
                                end
                            end
                            PH_OPEN_TOP, PH_OPEN_PLANE, PH_OPEN_ROW: begin
                                if (c == 8'h5B) begin
                                    n_phase = (r_phase == PH_OPEN_TOP)   ? PH_OPEN_PLANE :
                                              (r_phase == PH_OPEN_PLANE) ? PH_OPEN_ROW :
                                                                           PH_NUM_START;
                                end else begin
                                    n_err = ST_OPEN; n_phase = PH_ERR;
                                end
                            end
                            PH_NUM_START: begin
                                n_mag = '0;
                                n_neg = (c == 8'h2D);
                                if ((c == 8'h2D) || (c == 8'h2B)) begin
                                    n_phase = PH_NUM_SIGN;
                                end else if (is_digit(c)) begin
                                    n_mag   = MAG_W'(digit);
                                    n_phase = PH_NUM_DIGITS;
                                end else begin
                                    n_err = ST_NUMBER; n_phase = PH_ERR;
                                end
                            end
                            PH_NUM_SIGN: begin
                                if (is_digit(c)) begin
                                    n_mag   = MAG_W'(digit);
                                    n_phase = PH_NUM_DIGITS;
                                end else begin
                                    n_err = ST_NUMBER; n_phase = PH_ERR;
                                end
                            end
                            PH_NUM_DIGITS: begin
                                if (is_digit(c)) begin
                                    n_mag = acc[MAG_W-1:0];
                                    if (acc > limit) begin
                                        n_err = ST_NUMBER; n_phase = PH_ERR;
                                    end
                                end else begin
                                    // Emit the finished number, then check separator
                                    o_res_valid       = 1'b1;
                                    o_res.kind        = KIND_VALUE;
                                    o_res.value       = r_neg ? -r_mag[7:0] : r_mag[7:0];
                                    o_res.plane_index = r_plane;
                                    o_res.row_index   = r_row;
                                    o_res.col_index   = r_col;
                                    if (!col_last) begin
                                        if (c == 8'h2C) begin
                                            n_col = r_col + IDX_W'(1); n_phase = PH_NUM_START;
                                        end else begin
                                            n_err = ST_COMMA; n_phase = PH_ERR;
                                        end
                                    end else if (c == 8'h5D) begin
                                        n_col = '0; n_phase = PH_AFTER_ROW;
                                    end else begin
                                        n_err = ST_CLOSE; n_phase = PH_ERR;
                                    end
                                end
                            end
                            PH_AFTER_ROW: begin
                                if (!row_last) begin
                                    if (c == 8'h2C) begin
                                        n_row = r_row + IDX_W'(1); n_phase = PH_OPEN_ROW;
                                    end else begin
                                        n_err = ST_COMMA; n_phase = PH_ERR;
                                    end
                                end else if (c == 8'h5D) begin
                                    n_row = '0; n_phase = PH_AFTER_PLANE;
                                end else begin
                                    n_err = ST_CLOSE; n_phase = PH_ERR;
                                end
                            end
                            PH_AFTER_PLANE: begin
                                if (!plane_last) begin
                                    if (c == 8'h2C) begin
                                        n_plane = r_plane + IDX_W'(1); n_phase = PH_OPEN_PLANE;
                                    end else begin
                                        n_err = ST_COMMA; n_phase = PH_ERR;
                                    end
                                end else if (c == 8'h5D) begin
                                    n_plane = '0; n_phase = PH_DONE;
                                end else begin
                                    n_err = ST_CLOSE; n_phase = PH_ERR;
                                end
                            end
                            default: begin
                                n_phase = r_phase;
                            end
                        endcase
                    end
                end
            end
        end
    end

    // Parser state registers, advanced once per accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_KEY;
            r_key_pos <= '0;
            r_plane   <= '0;
            r_row     <= '0;
            r_col     <= '0;
            r_mag     <= '0;
            r_neg     <= 1'b0;
            r_bytes   <= '0;
            r_err     <= ST_OK;
        end else if (i_accept) begin
            r_phase   <= n_phase;
            r_key_pos <= n_key_pos;
            r_plane   <= n_plane;
            r_row     <= n_row;
            r_col     <= n_col;
            r_mag     <= n_mag;
            r_neg     <= n_neg;
            r_bytes   <= n_bytes;
            r_err     <= n_err;
        end
    end

endmodule

`default_nettype wire

// ===== tb/json_int8_tensor_parser_check.sv =====
`timescale 1ns / 1ps

// Watches the byte, result and size-register channels, predicts every result
// beat of the tensor parser and compares it against what the block returns.
module json_int8_tensor_parser_check (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_ready,
    input  jitp_pkg::t_in              i_in,
    input  logic                       i_out_valid,
    input  logic                       i_out_ready,
    input  jitp_pkg::t_out             i_out,
    input  logic                       i_cfg_valid,
    input  logic                       i_cfg_ready,
    input  logic [1:0]                 i_cfg_index,
    input  logic [jitp_pkg::DIM_W-1:0] i_cfg_data,
    output int                         o_errors,
    output int                         o_outstanding
);
    import jitp_pkg::*;

    localparam logic [7:0]  CH_QUOTE = 8'h22;
    localparam logic [7:0]  CH_PLUS  = 8'h2B;
    localparam logic [7:0]  CH_COMMA = 8'h2C;
    localparam logic [7:0]  CH_MINUS = 8'h2D;
    localparam logic [7:0]  CH_ZERO  = 8'h30;
    localparam logic [7:0]  CH_NINE  = 8'h39;
    localparam logic [7:0]  CH_COLON = 8'h3A;
    localparam logic [7:0]  CH_LBRK  = 8'h5B;
    localparam logic [7:0]  CH_RBRK  = 8'h5D;
    localparam logic [87:0] KEY_TEXT = {8'h22, 8'h69, 8'h6E, 8'h74, 8'h5F, 8'h76,
                                        8'h61, 8'h6C, 8'h75, 8'h65, 8'h22};
    localparam int          KEY_CHARS = 11;

    // Size registers as last written
    logic [DIM_W-1:0] size_planes, size_rows, size_cols;

    // Parser state
    t_phase          phase_now;
    int unsigned     key_pos;
    int unsigned     plane_at, row_at, col_at;
    longint unsigned mag;
    bit              minus;
    int unsigned     counted;
    t_status         first_err;

    t_out parse_results_due[$];
    int   fails = 0;

    assign o_errors = fails;

    function automatic int unsigned eff_dim(input logic [DIM_W-1:0] size);
        if (size == '0) return 1;
        if (size > DIM_MAX) return DIM_MAX;
        return size;
    endfunction

    function automatic bit is_dec(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic bit is_blank(input logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0B ||
               c == 8'h0C || c == 8'h0D;
    endfunction

    // Separator still due at one nesting level
    function automatic t_status sep_status(input int unsigned count,
                                           input logic [DIM_W-1:0] size);
        return (count + 1 < eff_dim(size)) ? ST_COMMA : ST_CLOSE;
    endfunction

    // Status for a file that stops here
    function automatic t_status status_at_end();
        case (phase_now)
            PH_KEY:                                  return ST_NO_KEY;
            PH_COLON:                                return ST_NO_COLON;
            PH_OPEN_TOP, PH_OPEN_PLANE, PH_OPEN_ROW: return ST_OPEN;
            PH_NUM_START, PH_NUM_SIGN:               return ST_NUMBER;
            PH_NUM_DIGITS:                           return sep_status(col_at, size_cols);
            PH_AFTER_ROW:                            return sep_status(row_at, size_rows);
            PH_AFTER_PLANE:                          return sep_status(plane_at, size_planes);
            PH_ERR:                                  return first_err;
            default:                                 return ST_OK;
        endcase
    endfunction

    task automatic restart_file();
        phase_now = PH_KEY;
        key_pos   = 0;
        plane_at  = 0;
        row_at    = 0;
        col_at    = 0;
        mag       = 0;
        minus     = 1'b0;
        counted   = 0;
        first_err = ST_OK;
    endtask

    task automatic fail_with(input t_status s);
        first_err = s;
        phase_now = PH_ERR;
    endtask

    // Expect ',' for more elements or ']' after the last one
    task automatic close_level(input logic [7:0] c, inout int unsigned count,
                               input logic [DIM_W-1:0] size,
                               input t_phase on_comma, input t_phase on_close);
        if (count + 1 < eff_dim(size)) begin
            if (c == CH_COMMA) begin
                count++;
                phase_now = on_comma;
            end else begin
                fail_with(ST_COMMA);
            end
        end else begin
            if (c == CH_RBRK) begin
                count = 0;
                phase_now = on_close;
            end else begin
                fail_with(ST_CLOSE);
            end
        end
    endtask

    // Advance the parser by one byte beat and queue any result it causes
    task automatic step_parser(input t_in b);
        t_out            r;
        logic [7:0]      c;
        longint unsigned twos;
        r = '0;
        c = b.byte_req;
        if (b.is_end) begin
            r.kind = KIND_STATUS;
            if (counted == 0) r.status = ST_EMPTY;
            else if (counted >= MAX_PAYLOAD) r.status = ST_TOO_LONG;
            else r.status = status_at_end();
            parse_results_due.push_back(r);
            restart_file();
            return;
        end
        if (is_blank(c)) return;
        if (counted >= MAX_PAYLOAD) return;
        if (counted >= MAX_PAYLOAD - 1) begin
            counted = MAX_PAYLOAD;
            return;
        end
        counted++;
        if (phase_now == PH_DONE || phase_now == PH_ERR) return;
        // A zero byte ends the text like the end of file
        if (c == 8'h00) begin
            fail_with(status_at_end());
            return;
        end
        case (phase_now)
            PH_KEY: begin
                if (key_pos < KEY_CHARS && c == KEY_TEXT[8*(KEY_CHARS-1-key_pos) +: 8])
                    key_pos++;
                else
                    key_pos = (c == CH_QUOTE) ? 1 : 0;
                if (key_pos >= KEY_CHARS) phase_now = PH_COLON;
            end
            PH_COLON: begin
                if (c == CH_COLON) phase_now = PH_OPEN_TOP;
                else fail_with(ST_NO_COLON);
            end
            PH_OPEN_TOP, PH_OPEN_PLANE, PH_OPEN_ROW: begin
                if (c != CH_LBRK) fail_with(ST_OPEN);
                else if (phase_now == PH_OPEN_TOP) phase_now = PH_OPEN_PLANE;
                else if (phase_now == PH_OPEN_PLANE) phase_now = PH_OPEN_ROW;
                else phase_now = PH_NUM_START;
            end
            PH_NUM_START: begin
                mag   = 0;
                minus = (c == CH_MINUS);
                if (c == CH_MINUS || c == CH_PLUS) begin
                    phase_now = PH_NUM_SIGN;
                end else if (is_dec(c)) begin
                    mag = c - CH_ZERO;
                    phase_now = PH_NUM_DIGITS;
                end else begin
                    fail_with(ST_NUMBER);
                end
            end
            PH_NUM_SIGN: begin
                if (is_dec(c)) begin
                    mag = c - CH_ZERO;
                    phase_now = PH_NUM_DIGITS;
                end else begin
                    fail_with(ST_NUMBER);
                end
            end
            PH_NUM_DIGITS: begin
                if (is_dec(c)) begin
                    mag = mag * 10 + (c - CH_ZERO);
                    if (mag > (minus ? 64'd2147483648 : 64'd2147483647))
                        fail_with(ST_NUMBER);
                end else begin
                    twos = minus ? (64'd0 - mag) : mag;
                    r.kind        = KIND_VALUE;
                    r.value       = twos[7:0];
                    r.plane_index = plane_at[IDX_W-1:0];
                    r.row_index   = row_at[IDX_W-1:0];
                    r.col_index   = col_at[IDX_W-1:0];
                    parse_results_due.push_back(r);
                    close_level(c, col_at, size_cols, PH_NUM_START, PH_AFTER_ROW);
                end
            end
            PH_AFTER_ROW:
                close_level(c, row_at, size_rows, PH_OPEN_ROW, PH_AFTER_PLANE);
            PH_AFTER_PLANE:
                close_level(c, plane_at, size_planes, PH_OPEN_PLANE, PH_DONE);
            default: ;
        endcase
    endtask

    task automatic note_failure(input string why, input t_out want, input t_out got);
        fails++;
        if (fails <= 10)
            $display("%0t: %s: expected kind=%0d value=%0d idx=%0d/%0d/%0d status=%0d",
                     $realtime, why, want.kind, want.value, want.plane_index,
                     want.row_index, want.col_index, want.status,
                     ", got kind=%0d value=%0d idx=%0d/%0d/%0d status=%0d",
                     got.kind, got.value, got.plane_index, got.row_index,
                     got.col_index, got.status);
    endtask

    // Sample every channel on the rising edge
    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            size_planes = 1;
            size_rows   = 1;
            size_cols   = 1;
            restart_file();
            parse_results_due.delete();
        end else begin
            // Compare the result beat before queueing new ones
            if (i_out_valid && i_out_ready) begin
                if (parse_results_due.size() == 0) begin
                    note_failure("result beat with nothing expected", '0, i_out);
                end else begin
                    want = parse_results_due.pop_front();
                    if (want.kind !== i_out.kind || want.value !== i_out.value ||
                        want.plane_index !== i_out.plane_index ||
                        want.row_index !== i_out.row_index ||
                        want.col_index !== i_out.col_index ||
                        want.status !== i_out.status)
                        note_failure("result mismatch", want, i_out);
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_NUM_PLANES: size_planes = i_cfg_data;
                    CFG_NUM_ROWS:   size_rows   = i_cfg_data;
                    CFG_NUM_COLS:   size_cols   = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) step_parser(i_in);
        end
        o_outstanding <= parse_results_due.size();
    end

endmodule

// ===== tb/json_int8_tensor_parser_test.sv =====
`timescale 1ns / 1ps

module json_int8_tensor_parser_test;
    import jitp_pkg::*;

    localparam int LIMIT_CYCLES  = 1_500_000;
    localparam int RANDOM_BEATS  = 1300;
    localparam int SETTLE_CYCLES = 4;

    localparam logic [7:0]       BLANKS [6]    = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
    localparam logic [7:0]       KEY_BYTES [11] = '{8'h22, 8'h69, 8'h6E, 8'h74, 8'h5F, 8'h76,
                                                    8'h61, 8'h6C, 8'h75, 8'h65, 8'h22};
    localparam logic [1:0]       REG_ORDER [3] = '{CFG_NUM_PLANES, CFG_NUM_ROWS, CFG_NUM_COLS};
    localparam logic [DIM_W-1:0] EXTREMES [5]  = '{13'd0, 13'd1, 13'd4096, 13'd4097, 13'd8191};

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic             in_ready;
    t_in              in_beat   = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    t_out             out_beat;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [1:0]       cfg_index = CFG_NUM_PLANES;
    logic [DIM_W-1:0] cfg_data  = '0;

    int               errors;
    int               outstanding;
    int               cycles     = 0;
    int               beats_sent = 0;
    bit               tx_calm    = 1'b0;
    bit               rx_calm    = 1'b0;
    logic [7:0]       file_bytes[$];
    logic [DIM_W-1:0] dims [3] = '{13'd1, 13'd1, 13'd1};

    always #6 clk = ~clk;

    json_int8_tensor_parser u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_beat),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    json_int8_tensor_parser_check u_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_in          (in_beat),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_out         (out_beat),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .o_errors      (errors),
        .o_outstanding (outstanding)
    );

    // Abort a hung run
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Result side: stall for a random time before each beat, except while calm
    initial begin
        int stall;
        do @(posedge clk); while (!rst_n);
        forever begin
            stall = rx_calm ? 0 : $urandom_range(0, 6);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            if ($urandom_range(0, 47) == 0) rx_calm = !rx_calm;
        end
    end

    // Hold one byte beat until it is taken
    task automatic send_beat(input logic [7:0] b, input logic last);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_beat  <= '{byte_req: b, is_end: last};
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        beats_sent++;
    endtask

    task automatic send_file();
        foreach (file_bytes[i]) send_beat(file_bytes[i], 1'b0);
        send_beat(8'($urandom_range(0, 255)), 1'b1);
        file_bytes.delete();
    endtask

    // Append text with whitespace sprinkled between characters
    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            if ($urandom_range(0, 9) == 0) file_bytes.push_back(BLANKS[$urandom_range(0, 5)]);
            file_bytes.push_back(s[i]);
        end
    endtask

    // Append the first n characters of the quoted key
    task automatic add_key(input int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0) file_bytes.push_back(BLANKS[$urandom_range(0, 5)]);
            file_bytes.push_back(KEY_BYTES[i]);
        end
    endtask

    task automatic add_number();
        int    pick;
        int    v;
        string s;
        pick = $urandom_range(0, 69);
        case (pick)
            0: s = "2147483647";
            1: s = "-2147483648";
            2: s = "+2147483648";
            3: s = "-2147483649";
            4: s = "00000000000000000127";
            5: s = "-0";
            6: s = "+";
            default: begin
                if (pick % 4 == 0) v = $urandom();
                else v = $urandom_range(0, 400) - 200;
                s = $sformatf("%0d", v);
                if (v >= 0 && $urandom_range(0, 3) == 0) s = {"+", s};
            end
        endcase
        add_text(s);
    endtask

    // Build one file shaped after the current sizes, sometimes off by one or broken
    task automatic gen_file();
        int shape [3];
        int k;
        int pos;
        if ($urandom_range(0, 15) == 0) begin
            repeat ($urandom_range(0, 5)) file_bytes.push_back(8'($urandom_range(1, 255)));
            return;
        end
        for (int i = 0; i < 3; i++) begin
            if (dims[i] == '0) shape[i] = 1;
            else if (dims[i] > 4) shape[i] = $urandom_range(1, 4);
            else shape[i] = dims[i];
        end
        if ($urandom_range(0, 7) == 0) begin
            k = $urandom_range(0, 2);
            shape[k] = (shape[k] > 1 && $urandom_range(0, 1) == 1) ? shape[k] - 1 : shape[k] + 1;
        end
        case ($urandom_range(0, 7))
            0: add_text("{\"in\"");
            1: add_text("\"\"");
            2: begin
                add_text("{");
                add_key(10);
                add_text("s\":0,");
                add_key(9);
            end
            3: repeat ($urandom_range(1, 4)) file_bytes.push_back(8'($urandom_range(1, 255)));
            default: add_text("{");
        endcase
        add_key(11);
        add_text(":[");
        for (int p = 0; p < shape[0]; p++) begin
            add_text("[");
            for (int r = 0; r < shape[1]; r++) begin
                add_text("[");
                for (int c = 0; c < shape[2]; c++) begin
                    add_number();
                    if (c < shape[2] - 1) add_text(",");
                end
                add_text("]");
                if (r < shape[1] - 1) add_text(",");
            end
            add_text("]");
            if (p < shape[0] - 1) add_text(",");
        end
        add_text("]");
        if ($urandom_range(0, 1) == 1) add_text("}");
        else repeat ($urandom_range(0, 3)) file_bytes.push_back(8'($urandom_range(1, 255)));
        // Corrupt one spot now and then
        if ($urandom_range(0, 3) == 0) begin
            pos = $urandom_range(0, file_bytes.size() - 1);
            case ($urandom_range(0, 3))
                0: file_bytes[pos] = 8'($urandom_range(0, 255));
                1: while (file_bytes.size() > pos) void'(file_bytes.pop_back());
                2: file_bytes.insert(pos, 8'h00);
                default: file_bytes.delete(pos);
            endcase
        end
    endtask

    // Drop valid and wait until every expected result has come back
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_sizes(input logic [DIM_W-1:0] p, input logic [DIM_W-1:0] r,
                               input logic [DIM_W-1:0] c);
        dims = '{p, r, c};
        for (int i = 0; i < 3; i++) begin
            cfg_index <= REG_ORDER[i];
            cfg_data  <= dims[i];
            cfg_valid <= 1'b1;
            do @(posedge clk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty file, whitespace only, one value at reset sizes
        send_file();
        foreach (BLANKS[i]) file_bytes.push_back(BLANKS[i]);
        send_file();
        add_key(11);
        add_text(":[[[-128]]]");
        send_file();

        // Random phases; the first one uses extreme sizes
        settle();
        write_sizes(13'd0, 13'd8191, 13'd4096);
        while (beats_sent < RANDOM_BEATS) begin
            repeat ($urandom_range(1, 3)) begin
                tx_calm = ($urandom_range(0, 4) == 0);
                gen_file();
                send_file();
            end
            settle();
            if ($urandom_range(0, 3) == 0)
                write_sizes(EXTREMES[$urandom_range(0, 4)], EXTREMES[$urandom_range(0, 4)],
                            EXTREMES[$urandom_range(0, 4)]);
            else
                write_sizes(DIM_W'($urandom_range(1, 3)), DIM_W'($urandom_range(1, 3)),
                            DIM_W'($urandom_range(1, 3)));
        end

        settle();
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/jitp_pkg.sv
design/jitp_core.sv
design/json_int8_tensor_parser.sv
tb/json_int8_tensor_parser_check.sv
tb/json_int8_tensor_parser_test.sv
